// ----- hw/rtl/pvl_pkg.sv -----
// Shared constants, widths, register codes and pipeline control type for vertex lighting.
package pvl_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] REG_EYE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEC  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHINE = 3'd5;

  localparam logic [CFG_DATA_W-1:0] EYE_RST   = 48'd52776558133248;
  localparam logic [CFG_DATA_W-1:0] LIGHT_RST = 48'd17592320264192;
  localparam logic [CFG_DATA_W-1:0] AMB_RST   = 48'd9852880491446;
  localparam logic [CFG_DATA_W-1:0] DIFF_RST  = 48'd65302091553571;
  localparam logic [CFG_DATA_W-1:0] SPEC_RST  = 48'd49259731561677;

  // Fixed-point formats
  localparam int NORM_W  = 16;   // Q1.14 normal component
  localparam int UNIT_W  = 16;   // Q1.14 unit vector component
  localparam int GAIN_W  = 16;   // Q1.15 gain / color channel
  localparam int SHINE_W = 8;
  localparam logic [SHINE_W-1:0] SHINE_RST = 8'd120;
  localparam int PW_W    = 15;   // clamped Q1.14 in 0..1.0
  localparam int DOT_W   = 18;   // raw n.l, normal used as given
  localparam int NLC_W   = 17;   // n.l clamped at zero
  localparam int DR_W    = 22;   // unnormalized reflection vector
  localparam logic [PW_W-1:0] ONE_Q14 = 15'd16384;
  localparam int COLOR_MAX = 32768;

  // Normalizer
  localparam int NRM_W      = 30;                  // the largest magnitude lands in [2^29, 2^30)
  localparam int SQ_W       = 2 * NRM_W + 2;       // sum of three squares
  localparam int SQRT_STEPS = SQ_W / 2;            // one result bit per stage
  localparam int MAG_W      = 32;
  localparam int DIV_STEPS  = 16;                  // quotient stays below 2^16
  localparam int NUM_W      = NRM_W + 14 + 1;
  localparam int UNIT_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;

  localparam int POW_STEPS  = (1 << SHINE_W) - 1;

  typedef struct packed {
    logic adv;   // whole pipeline moves this cycle
    logic vld;   // beat entering the unit is real
  } pipe_ctl_t;

endpackage

// ----- hw/rtl/pvl_unitize.sv -----
// Pipelined vector normalizer: scale, sum of squares, bit-serial sqrt, per-lane divide.
module pvl_unitize import pvl_pkg::*; #(
  parameter int DW     = 17,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pipe_ctl_t                ctl,
  input  logic signed [DW-1:0]     d_x,
  input  logic signed [DW-1:0]     d_y,
  input  logic signed [DW-1:0]     d_z,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     vld_out,
  output logic signed [UNIT_W-1:0] u_x,
  output logic signed [UNIT_W-1:0] u_y,
  output logic signed [UNIT_W-1:0] u_z,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int LAT  = UNIT_LAT;
  localparam int POSW = $clog2(DW);
  localparam int FLGN = LAT - 1;

  logic [LAT-1:0]    vq;
  logic [SIDE_W-1:0] sd_q [LAT];
  logic [3:0]        flg_q [FLGN];   // {zero, neg z, neg y, neg x}

  logic signed [DW-1:0] d_in [3];
  assign d_in[0] = d_x;
  assign d_in[1] = d_y;
  assign d_in[2] = d_z;

  // stage A: magnitudes
  logic [DW-1:0] a_abs [3];
  logic [DW-1:0] a_or;
  logic [DW-1:0] a_abs_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_abs_c[i] = d_in[i][DW-1] ? DW'(-d_in[i]) : DW'(d_in[i]);
    end
  end

  // stage B: common power-of-two scale from the top bit of the OR word
  logic [POSW-1:0] pos;
  logic [NRM_W-1:0] an_b [3];
  always_comb begin
    pos = '0;
    for (int b = 0; b < DW; b++) begin
      if (a_or[b]) pos = POSW'(b);
    end
  end

  // stage C / D: squares and their sum
  logic [2*NRM_W-1:0] sq [3];
  logic [NRM_W-1:0]   an_c [3];
  logic [SQ_W-1:0]    ssum;
  logic [NRM_W-1:0]   an_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (ctl.adv) begin
      vq <= {vq[LAT-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sd_q[0]  <= side_in;
      for (int k = 1; k < LAT; k++) sd_q[k] <= sd_q[k-1];
      flg_q[0] <= {((a_abs_c[0] | a_abs_c[1] | a_abs_c[2]) == '0),
                   d_z[DW-1], d_y[DW-1], d_x[DW-1]};
      for (int k = 1; k < FLGN; k++) flg_q[k] <= flg_q[k-1];
      a_or <= a_abs_c[0] | a_abs_c[1] | a_abs_c[2];
      for (int i = 0; i < 3; i++) begin
        a_abs[i] <= a_abs_c[i];
        an_b[i]  <= NRM_W'({a_abs[i], {(NRM_W-1){1'b0}}} >> pos);
        sq[i]    <= an_b[i] * an_b[i];
        an_c[i]  <= an_b[i];
        an_d[i]  <= an_c[i];
      end
      ssum <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]);
    end
  end

  // integer square root, one result bit per stage
  logic [SQ_W-1:0]  sx [SQRT_STEPS];
  logic [SQ_W-1:0]  sr [SQRT_STEPS];
  logic [NRM_W-1:0] san [SQRT_STEPS][3];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2 * j);
    logic [SQ_W-1:0]  x_in;
    logic [SQ_W-1:0]  r_in;
    logic [SQ_W-1:0]  trial;
    logic [NRM_W-1:0] an_in [3];
    if (j == 0) begin : g_first
      assign x_in = ssum;
      assign r_in = '0;
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign an_in[i] = an_d[i];
      end
    end else begin : g_rest
      assign x_in = sx[j-1];
      assign r_in = sr[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign an_in[i] = san[j-1][i];
      end
    end
    assign trial = r_in + BITV;
    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        if (x_in >= trial) begin
          sx[j] <= x_in - trial;
          sr[j] <= (r_in >> 1) + BITV;
        end else begin
          sx[j] <= x_in;
          sr[j] <= r_in >> 1;
        end
        for (int i = 0; i < 3; i++) san[j][i] <= an_in[i];
      end
    end
  end

  // rounded restoring divide, one quotient bit per stage, three lanes
  logic [NUM_W-1:0]     drem [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] dq   [DIV_STEPS][3];
  logic [MAG_W-1:0]     dmag [DIV_STEPS];

  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    localparam int K = DIV_STEPS - 1 - t;
    logic [MAG_W-1:0]     mag_in;
    logic [NUM_W-1:0]     rem_in [3];
    logic [DIV_STEPS-1:0] q_in [3];
    logic [NUM_W+2:0]     dvs;
    if (t == 0) begin : g_first
      assign mag_in = sr[SQRT_STEPS-1][MAG_W-1:0];
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign rem_in[i] = NUM_W'({san[SQRT_STEPS-1][i], 14'b0}) + NUM_W'(mag_in >> 1);
        assign q_in[i]   = '0;
      end
    end else begin : g_rest
      assign mag_in = dmag[t-1];
      for (genvar i = 0; i < 3; i++) begin : g_l
        assign rem_in[i] = drem[t-1][i];
        assign q_in[i]   = dq[t-1][i];
      end
    end
    assign dvs = (NUM_W+3)'(mag_in) << K;
    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        dmag[t] <= mag_in;
        for (int i = 0; i < 3; i++) begin
          if ((NUM_W+3)'(rem_in[i]) >= dvs) begin
            drem[t][i] <= NUM_W'((NUM_W+3)'(rem_in[i]) - dvs);
            dq[t][i]   <= q_in[i] | (DIV_STEPS'(1) << K);
          end else begin
            drem[t][i] <= rem_in[i];
            dq[t][i]   <= q_in[i];
          end
        end
      end
    end
  end

  // output: sign back, zero vector stays zero
  logic signed [UNIT_W-1:0] qs [3];
  logic signed [UNIT_W-1:0] u_q [3];
  always_comb begin
    for (int i = 0; i < 3; i++) qs[i] = signed'(UNIT_W'(dq[DIV_STEPS-1][i]));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int i = 0; i < 3; i++) begin
        if (flg_q[FLGN-1][3]) u_q[i] <= '0;
        else if (flg_q[FLGN-1][i]) u_q[i] <= -qs[i];
        else u_q[i] <= qs[i];
      end
    end
  end

  assign u_x      = u_q[0];
  assign u_y      = u_q[1];
  assign u_z      = u_q[2];
  assign vld_out  = vq[LAT-1];
  assign side_out = sd_q[LAT-1];

endmodule

// ----- hw/rtl/pvl_power.sv -----
// Specular power chain: one rounded Q1.14 multiply per stage, gated by the exponent.
module pvl_power import pvl_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctl_t          ctl,
  input  logic [SHINE_W-1:0] shine,
  input  logic [PW_W-1:0]    rv_in,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               vld_out,
  output logic [PW_W-1:0]    pw_out,
  output logic [SIDE_W-1:0]  side_out
);

  logic [POW_STEPS-1:0] vq;
  logic [PW_W-1:0]      pw_q [POW_STEPS];
  logic [PW_W-1:0]      rv_q [POW_STEPS];
  logic [SIDE_W-1:0]    sd_q [POW_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (ctl.adv) begin
      vq <= {vq[POW_STEPS-2:0], ctl.vld};
    end
  end

  for (genvar k = 0; k < POW_STEPS; k++) begin : g_step
    logic [PW_W-1:0]   pw_in;
    logic [PW_W-1:0]   rv_s;
    logic [SIDE_W-1:0] sd_in;
    logic [2*PW_W:0]   prod;
    if (k == 0) begin : g_first
      assign pw_in = ONE_Q14;
      assign rv_s  = rv_in;
      assign sd_in = side_in;
    end else begin : g_rest
      assign pw_in = pw_q[k-1];
      assign rv_s  = rv_q[k-1];
      assign sd_in = sd_q[k-1];
    end
    assign prod = (2*PW_W+1)'(pw_in) * (2*PW_W+1)'(rv_s) + (2*PW_W+1)'(8192);
    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        pw_q[k] <= (SHINE_W'(k) < shine) ? PW_W'(prod >> 14) : pw_in;
        rv_q[k] <= rv_s;
        sd_q[k] <= sd_in;
      end
    end
  end

  assign vld_out  = vq[POW_STEPS-1];
  assign pw_out   = pw_q[POW_STEPS-1];
  assign side_out = sd_q[POW_STEPS-1];

endmodule

// ----- hw/rtl/phong_vertex_lighting.sv -----
// Top level: per-vertex Phong lighting pipeline with stream ports and a register write port.
//
// Per-vertex Phong lighting. Each input beat carries a vertex position (signed Q4.12,
// COORD_WIDTH bits per axis) and a normal (signed Q1.14, used as given); each output beat
// carries one color, ambient + diffuse*max(n.l,0) + specular*max(r.v,0)^shine per channel,
// unsigned Q1.15 saturated to 1.0, with tlast copied from the input. The block is a fully
// pipelined datapath: while the output is not stalled, a new vertex is accepted every
// cycle and one color leaves every cycle. The path runs through two normalizers in series
// (each: scale, squares, a 31-stage square root and a 16-stage divider) and the 255-stage
// specular power chain, one multiply per possible exponent step. A stall on the output
// freezes the whole pipe; s_tready is low only while a finished color waits. Registers are
// written through cfg_we/cfg_idx/cfg_data and take effect for beats accepted afterwards;
// write them only while no vertex is in flight. Unknown indexes are ignored.
module phong_vertex_lighting import pvl_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_BITS    = 3 * COORD_WIDTH + 3 * NORM_W,
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int M_TDATA_W  = 3 * GAIN_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x, pos_y, pos_z (COORD_WIDTH each), norm_x, norm_y, norm_z (16 each), zero fill
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,   // last_vertex
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // color_red, color_green, color_blue (16 each)
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tlast,   // last_out
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int EXT_W = 3 * CW + CFG_DATA_W;

  // ---------------- configuration registers ----------------
  logic [CFG_DATA_W-1:0] eye_position, light_position;
  logic [CFG_DATA_W-1:0] ambient_term, diffuse_gain, specular_gain;
  logic [SHINE_W-1:0]    shine_exponent;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_position   <= EYE_RST;
      light_position <= LIGHT_RST;
      ambient_term   <= AMB_RST;
      diffuse_gain   <= DIFF_RST;
      specular_gain  <= SPEC_RST;
      shine_exponent <= SHINE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_EYE:   eye_position   <= cfg_data;
        REG_LIGHT: light_position <= cfg_data;
        REG_AMB:   ambient_term   <= cfg_data;
        REG_DIFF:  diffuse_gain   <= cfg_data;
        REG_SPEC:  specular_gain  <= cfg_data;
        REG_SHINE: shine_exponent <= cfg_data[SHINE_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate fields; fields past the 48 register bits read as zero
  logic [EXT_W-1:0] eye_ext, light_ext;
  assign eye_ext   = EXT_W'(eye_position);
  assign light_ext = EXT_W'(light_position);

  // whole pipe advances unless the output holds an untaken color
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // round Q?.28 products back to Q1.14, half toward +inf
  function automatic logic signed [DOT_W-1:0] dot_round(input logic signed [34:0] s);
    logic signed [34:0] t;
    t = s + 35'sd8192;
    return DOT_W'(t >>> 14);
  endfunction

  // ---------------- T1: vectors toward light and eye ----------------
  logic                   v1;
  logic signed [CW:0]     dl [3];
  logic signed [CW:0]     dv [3];
  logic [3*NORM_W-1:0]    n1;
  logic                   last1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dl[i] <= (CW+1)'(signed'(light_ext[i*CW +: CW])) - (CW+1)'(signed'(s_tdata[i*CW +: CW]));
        dv[i] <= (CW+1)'(signed'(eye_ext[i*CW +: CW])) - (CW+1)'(signed'(s_tdata[i*CW +: CW]));
      end
      n1    <= s_tdata[3*CW +: 3*NORM_W];
      last1 <= s_tlast;
    end
  end

  // ---------------- unit l and v (normal rides along with l) ----------------
  logic                     vld_l, vld_v, vu;
  logic signed [UNIT_W-1:0] l_u [3];
  logic signed [UNIT_W-1:0] v_u [3];
  logic [3*NORM_W-1:0]      n_u;
  logic                     last_u;

  pvl_unitize #(.DW(CW + 1), .SIDE_W(3 * NORM_W)) u_light (
    .clk(clk), .rst(rst), .ctl('{adv: adv, vld: v1}),
    .d_x(dl[0]), .d_y(dl[1]), .d_z(dl[2]), .side_in(n1),
    .vld_out(vld_l), .u_x(l_u[0]), .u_y(l_u[1]), .u_z(l_u[2]), .side_out(n_u)
  );

  pvl_unitize #(.DW(CW + 1), .SIDE_W(1)) u_eye (
    .clk(clk), .rst(rst), .ctl('{adv: adv, vld: v1}),
    .d_x(dv[0]), .d_y(dv[1]), .d_z(dv[2]), .side_in(last1),
    .vld_out(vld_v), .u_x(v_u[0]), .u_y(v_u[1]), .u_z(v_u[2]), .side_out(last_u)
  );

  assign vu = vld_l & vld_v;

  // ---------------- T2/T3: n.l ----------------
  logic                     v2, v3;
  logic signed [31:0]       pnl [3];
  logic signed [NORM_W-1:0] n2 [3], n3 [3];
  logic signed [UNIT_W-1:0] l2 [3], l3 [3];
  logic signed [UNIT_W-1:0] vv2 [3], vv3 [3];
  logic                     last2, last3;
  logic signed [DOT_W-1:0]  nl3;

  // ---------------- T4/T5: reflection vector ----------------
  logic                     v4, v5;
  logic signed [33:0]       pn [3];
  logic signed [UNIT_W-1:0] l4 [3], vv4 [3], vv5 [3];
  logic signed [DOT_W-1:0]  nl4, nl5;
  logic                     last4, last5;
  logic signed [DR_W-1:0]   dr [3];
  logic signed [35:0]       two_pn [3];

  always_comb begin
    for (int i = 0; i < 3; i++) two_pn[i] = (36'(pn[i]) <<< 1) + 36'sd8192;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (adv) begin
      v2 <= vu; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n2[i]  <= signed'(n_u[i*NORM_W +: NORM_W]);
        pnl[i] <= signed'(n_u[i*NORM_W +: NORM_W]) * l_u[i];
        l2[i]  <= l_u[i];
        vv2[i] <= v_u[i];
        n3[i]  <= n2[i];
        l3[i]  <= l2[i];
        vv3[i] <= vv2[i];
        pn[i]  <= nl3 * n3[i];
        l4[i]  <= l3[i];
        vv4[i] <= vv3[i];
        dr[i]  <= DR_W'(two_pn[i] >>> 14) - DR_W'(l4[i]);
        vv5[i] <= vv4[i];
      end
      nl3   <= dot_round(35'(pnl[0]) + 35'(pnl[1]) + 35'(pnl[2]));
      nl4   <= nl3;
      nl5   <= nl4;
      last2 <= last_u;
      last3 <= last2;
      last4 <= last3;
      last5 <= last4;
    end
  end

  // ---------------- unit r (v, n.l and tlast ride along) ----------------
  localparam int RSIDE_W = 3 * UNIT_W + DOT_W + 1;
  logic                     vr;
  logic signed [UNIT_W-1:0] r_u [3];
  logic [RSIDE_W-1:0]       rside;
  logic signed [UNIT_W-1:0] v_r [3];
  logic signed [DOT_W-1:0]  nl_r;
  logic                     last_r;

  pvl_unitize #(.DW(DR_W), .SIDE_W(RSIDE_W)) u_refl (
    .clk(clk), .rst(rst), .ctl('{adv: adv, vld: v5}),
    .d_x(dr[0]), .d_y(dr[1]), .d_z(dr[2]),
    .side_in({vv5[2], vv5[1], vv5[0], nl5, last5}),
    .vld_out(vr), .u_x(r_u[0]), .u_y(r_u[1]), .u_z(r_u[2]), .side_out(rside)
  );

  assign {v_r[2], v_r[1], v_r[0], nl_r, last_r} = rside;

  // ---------------- T6/T7: r.v clamped, n.l clamped ----------------
  logic                    v6, v7;
  logic signed [31:0]      prv [3];
  logic signed [DOT_W-1:0] nl6;
  logic                    last6, last7;
  logic signed [DOT_W-1:0] rv_s;
  logic [PW_W-1:0]         rv7;
  logic [NLC_W-1:0]        nlc7;

  assign rv_s = dot_round(35'(prv[0]) + 35'(prv[1]) + 35'(prv[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0; v7 <= 1'b0;
    end else if (adv) begin
      v6 <= vr; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) prv[i] <= r_u[i] * v_r[i];
      nl6   <= nl_r;
      last6 <= last_r;
      priority if (rv_s < 0) rv7 <= '0;
      else if (rv_s > DOT_W'(ONE_Q14)) rv7 <= ONE_Q14;
      else rv7 <= PW_W'(rv_s);
      nlc7  <= (nl6 < 0) ? '0 : NLC_W'(nl6);
      last7 <= last6;
    end
  end

  // ---------------- specular power ----------------
  logic             vp;
  logic [PW_W-1:0]  pw_p;
  logic [NLC_W-1:0] nlc_p;
  logic             last_p;

  pvl_power #(.SIDE_W(NLC_W + 1)) u_power (
    .clk(clk), .rst(rst), .ctl('{adv: adv, vld: v7}),
    .shine(shine_exponent), .rv_in(rv7), .side_in({nlc7, last7}),
    .vld_out(vp), .pw_out(pw_p), .side_out({nlc_p, last_p})
  );

  // ---------------- T8: channel products ----------------
  logic                      v8, last8;
  logic [GAIN_W+NLC_W-1:0]   mul_d [3];
  logic [GAIN_W+PW_W-1:0]    mul_s [3];

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= vp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        mul_d[c] <= diffuse_gain[c*GAIN_W +: GAIN_W] * nlc_p;
        mul_s[c] <= specular_gain[c*GAIN_W +: GAIN_W] * pw_p;
      end
      last8 <= last_p;
    end
  end

  // ---------------- T9: sum, round, saturate into the output register ----------------
  logic [34:0] tot [3];
  logic [20:0] col [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = (35'(ambient_term[c*GAIN_W +: GAIN_W]) << 14) + 35'(mul_d[c])
             + 35'(mul_s[c]) + 35'd8192;
      col[c] = tot[c][34:14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= v8;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        m_tdata[c*GAIN_W +: GAIN_W] <= (col[c] > 21'(COLOR_MAX)) ? GAIN_W'(COLOR_MAX)
                                                                  : col[c][GAIN_W-1:0];
      end
      m_tlast <= last8;
    end
  end

  // ---------------- assertions ----------------
  a_color_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= 16'(COLOR_MAX)) && (m_tdata[31:16] <= 16'(COLOR_MAX))
                 && (m_tdata[47:32] <= 16'(COLOR_MAX)))
    else $error("color channel above 1.0");

  a_lanes_step: assert property (@(posedge clk) disable iff (rst)
    vld_l == vld_v)
    else $error("light and eye normalizers out of step");

  a_pow_range: assert property (@(posedge clk) disable iff (rst)
    vp |-> pw_p <= ONE_Q14)
    else $error("specular power above 1.0");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(v8))
    else $error("stalled pipe moved");

endmodule
